/* design/amou_pkg.sv */
`timescale 1ns / 1ps

package amou_pkg;

    typedef enum logic [3:0] {
        CMD_LR   = 4'd0,
        CMD_SC   = 4'd1,
        CMD_SWAP = 4'd2,
        CMD_ADD  = 4'd3,
        CMD_OR   = 4'd4,
        CMD_AND  = 4'd5,
        CMD_XOR  = 4'd6,
        CMD_MAXU = 4'd7,
        CMD_MAX  = 4'd8,
        CMD_MINU = 4'd9,
        CMD_MIN  = 4'd10
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_NOP,
        KIND_LR,
        KIND_SC,
        KIND_AMO
    } t_kind;

    // One decoded instruction as it waits between decode and execute.
    typedef struct packed {
        t_kind       kind;
        t_cmd        cmd;
        logic        is_double;
        logic [63:0] addr;
        logic [63:0] old;
        logic [63:0] src;
    } t_item;

    localparam int QueueDepth = 2;

    function automatic logic [63:0] sext32(input logic [63:0] v);
        return {{32{v[31]}}, v[31:0]};
    endfunction

endpackage

/* design/amou_front.sv */
`timescale 1ns / 1ps

module amou_front (
    input  logic [3:0]     i_cmd,
    input  logic           i_is_double,
    input  logic [63:0]    i_phys_addr,
    input  logic [63:0]    i_operand,
    input  logic [63:0]    i_mem_old,
    output amou_pkg::t_item o_item
);

    logic [3:0] w_cmd;

    assign w_cmd = i_cmd;

    always_comb begin
        o_item.cmd       = amou_pkg::t_cmd'(w_cmd);
        o_item.is_double = i_is_double;
        o_item.addr      = i_phys_addr;
        // Word accesses work on sign-extended low halves throughout.
        o_item.old       = i_is_double ? i_mem_old : amou_pkg::sext32(i_mem_old);
        o_item.src       = i_is_double ? i_operand : amou_pkg::sext32(i_operand);
        if (w_cmd == amou_pkg::CMD_LR) begin
            o_item.kind = amou_pkg::KIND_LR;
        end else if (w_cmd == amou_pkg::CMD_SC) begin
            o_item.kind = amou_pkg::KIND_SC;
        end else if (w_cmd inside {[amou_pkg::CMD_SWAP:amou_pkg::CMD_MIN]}) begin
            o_item.kind = amou_pkg::KIND_AMO;
        end else begin
            o_item.kind = amou_pkg::KIND_NOP;
        end
    end

endmodule

/* design/amou_queue.sv */
`timescale 1ns / 1ps

module amou_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  amou_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output amou_pkg::t_item o_item
);

    localparam int PtrW = $clog2(amou_pkg::QueueDepth);
    localparam int CntW = $clog2(amou_pkg::QueueDepth + 1);

    amou_pkg::t_item r_mem [amou_pkg::QueueDepth];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count, n_count;
    logic            w_push, w_pop;

    assign o_full  = (r_count == CntW'(amou_pkg::QueueDepth));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(amou_pkg::QueueDepth - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(amou_pkg::QueueDepth - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

/* design/amou_back.sv */
`timescale 1ns / 1ps

module amou_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_head_valid,
    input  amou_pkg::t_item i_head,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [63:0]     o_rd_value,
    output logic            o_store_enable,
    output logic [63:0]     o_store_data
);

    logic        r_valid, n_valid;
    logic [63:0] r_rd_value, n_rd_value;
    logic        r_store_enable, n_store_enable;
    logic [63:0] r_store_data, n_store_data;
    logic [63:0] r_res_addr, n_res_addr;
    logic        r_res_valid, n_res_valid;

    logic [63:0] w_mask, w_uold, w_usrc, w_nv;
    logic        w_sc_ok, w_slt_src_old, w_slt_old_src;

    // The output register is free when empty or when its transfer completes now.
    assign o_pop = i_head_valid && (!r_valid || !i_stall);

    assign w_mask  = i_head.is_double ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
    assign w_uold  = i_head.old & w_mask;
    assign w_usrc  = i_head.src & w_mask;
    assign w_sc_ok = r_res_valid && (r_res_addr == i_head.addr);
    // Operands are sign-extended, so a 64-bit signed compare also serves words.
    assign w_slt_src_old = $signed(i_head.src) < $signed(i_head.old);
    assign w_slt_old_src = $signed(i_head.old) < $signed(i_head.src);

    always_comb begin
        case (i_head.cmd)
            amou_pkg::CMD_SWAP: w_nv = i_head.src;
            amou_pkg::CMD_ADD:  w_nv = i_head.old + i_head.src;
            amou_pkg::CMD_OR:   w_nv = i_head.old | i_head.src;
            amou_pkg::CMD_AND:  w_nv = i_head.old & i_head.src;
            amou_pkg::CMD_XOR:  w_nv = i_head.old ^ i_head.src;
            amou_pkg::CMD_MAXU: w_nv = (w_uold > w_usrc) ? i_head.old : i_head.src;
            amou_pkg::CMD_MAX:  w_nv = w_slt_src_old ? i_head.old : i_head.src;
            amou_pkg::CMD_MINU: w_nv = (w_uold < w_usrc) ? i_head.old : i_head.src;
            amou_pkg::CMD_MIN:  w_nv = w_slt_old_src ? i_head.old : i_head.src;
            default:            w_nv = '0;
        endcase
    end

    always_comb begin
        n_valid        = r_valid;
        n_rd_value     = r_rd_value;
        n_store_enable = r_store_enable;
        n_store_data   = r_store_data;
        n_res_addr     = r_res_addr;
        n_res_valid    = r_res_valid;
        if (r_valid && !i_stall) begin
            n_valid = 1'b0;
        end
        if (o_pop) begin
            n_valid        = 1'b1;
            n_rd_value     = '0;
            n_store_enable = 1'b0;
            n_store_data   = '0;
            case (i_head.kind)
                amou_pkg::KIND_LR: begin
                    n_rd_value  = i_head.old;
                    n_res_addr  = i_head.addr;
                    n_res_valid = 1'b1;
                end
                amou_pkg::KIND_SC: begin
                    n_res_valid    = 1'b0;
                    n_rd_value     = {63'd0, !w_sc_ok};
                    n_store_enable = w_sc_ok;
                    n_store_data   = w_sc_ok ? w_usrc : '0;
                end
                amou_pkg::KIND_AMO: begin
                    n_rd_value     = i_head.old;
                    n_store_enable = 1'b1;
                    n_store_data   = w_nv & w_mask;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_res_valid <= 1'b0;
            r_res_addr  <= '0;
        end else begin
            r_valid     <= n_valid;
            r_res_valid <= n_res_valid;
            r_res_addr  <= n_res_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_value     <= n_rd_value;
        r_store_enable <= n_store_enable;
        r_store_data   <= n_store_data;
    end

    assign o_valid        = r_valid;
    assign o_rd_value     = r_rd_value;
    assign o_store_enable = r_store_enable;
    assign o_store_data   = r_store_data;

endmodule

/* design/riscv_atomic_memory_op_unit_core.sv */
`timescale 1ns / 1ps
// An accepted input is written into the queue; the execute stage then pops it
// and registers its result in the output register, from which it is transferred.
// Throughput: one atomic instruction per cycle while the output is not stalled, set
// by the execute stage with its one reservation compare; a two-entry queue sits
// between decode and execute. Reset (synchronous, active low) empties the
// queue and the output register and clears the reservation.

module riscv_atomic_memory_op_unit_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_cmd,
    input  logic        i_is_double,
    input  logic [63:0] i_phys_addr,
    input  logic [63:0] i_operand,
    input  logic [63:0] i_mem_old,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_rd_value,
    output logic        o_store_enable,
    output logic [63:0] o_store_data
);

    amou_pkg::t_item w_dec_item;
    amou_pkg::t_item w_head;
    logic            w_full, w_head_valid, w_pop;

    amou_front u_front (
        .i_cmd       (i_cmd),
        .i_is_double (i_is_double),
        .i_phys_addr (i_phys_addr),
        .i_operand   (i_operand),
        .i_mem_old   (i_mem_old),
        .o_item      (w_dec_item)
    );

    amou_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_item  (w_dec_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_item  (w_head)
    );

    amou_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head_valid   (w_head_valid),
        .i_head         (w_head),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_rd_value     (o_rd_value),
        .o_store_enable (o_store_enable),
        .o_store_data   (o_store_data)
    );

    assign o_stall = w_full;

endmodule
